// File: hdl/cbcr_pkg.sv
// shared types, codes and constants for the circle versus box collision block
`default_nettype none
package cbcr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int RADIUS_INT    = 20;
  localparam int AXIS_BITS     = 14;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 15;
  localparam int CNT_W         = 5;
  localparam int CFG_IDX_W     = 3;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_MOVE    = 2'd1;
  localparam logic [1:0] KIND_COLLIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_VX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_VY = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_EX,
    ST_SQX, ST_SQY, ST_DSQ, ST_TST, ST_SQRT, ST_DIVI, ST_DIV,
    ST_N1, ST_N2, ST_N3, ST_N4, ST_N5, ST_N6, ST_N7, ST_N8, ST_N9,
    ST_N10, ST_N11, ST_N12, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_EXEC, OP_DIFF, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_EX,
    OP_SQX, OP_SQY, OP_DSQ, OP_TST, OP_SQRT, OP_DIVI, OP_DIV,
    OP_N1, OP_N2, OP_N3, OP_N4, OP_N5, OP_N6, OP_N7, OP_N8, OP_N9,
    OP_N10, OP_N11, OP_N12
  } op_t;

  typedef struct packed {
    logic latch;
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       far;
    logic       miss;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/cbcr_ctrl.sv
// sequencer for one command: dispatch, collision steps, result hand-off
`default_nettype none
module cbcr_ctrl
  import cbcr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic    out_ready,
  output logic         out_valid,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_TST || state == ST_DIVI) begin
        cnt <= '0;
      end else if (state == ST_SQRT || state == ST_DIV) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: state_next = (st.kind == KIND_COLLIDE) ? ST_P1 : ST_FIN;
      ST_P1:       state_next = ST_P2;
      ST_P2:       state_next = ST_P3;
      ST_P3:       state_next = ST_P4;
      ST_P4:       state_next = ST_P5;
      ST_P5:       state_next = ST_EX;
      ST_EX:       state_next = ST_SQX;
      ST_SQX:      state_next = st.far ? ST_FIN : ST_SQY;
      ST_SQY:      state_next = ST_DSQ;
      ST_DSQ:      state_next = ST_TST;
      ST_TST:      state_next = st.miss ? ST_FIN : ST_SQRT;
      ST_SQRT:     if (cnt == CNT_W'(SQRT_STEPS - 1)) state_next = ST_DIVI;
      ST_DIVI:     state_next = ST_DIV;
      ST_DIV:      if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_N1;
      ST_N1:       state_next = ST_N2;
      ST_N2:       state_next = ST_N3;
      ST_N3:       state_next = ST_N4;
      ST_N4:       state_next = ST_N5;
      ST_N5:       state_next = ST_N6;
      ST_N6:       state_next = ST_N7;
      ST_N7:       state_next = ST_N8;
      ST_N8:       state_next = ST_N9;
      ST_N9:       state_next = ST_N10;
      ST_N10:      state_next = ST_N11;
      ST_N11:      state_next = ST_N12;
      ST_N12:      state_next = ST_FIN;
      ST_FIN:      if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_IDLE);
    cmd.latch    = (state == ST_IDLE) && in_valid;
    cmd.out_load = (state == ST_FIN) && (!out_valid || out_ready);
    cmd.op       = OP_NONE;
    unique case (state)
      ST_IDLE:     cmd.op = OP_NONE;
      ST_DISPATCH: cmd.op = (st.kind == KIND_COLLIDE) ? OP_DIFF : OP_EXEC;
      ST_P1:       cmd.op = OP_P1;
      ST_P2:       cmd.op = OP_P2;
      ST_P3:       cmd.op = OP_P3;
      ST_P4:       cmd.op = OP_P4;
      ST_P5:       cmd.op = OP_P5;
      ST_EX:       cmd.op = OP_EX;
      ST_SQX:      cmd.op = OP_SQX;
      ST_SQY:      cmd.op = OP_SQY;
      ST_DSQ:      cmd.op = OP_DSQ;
      ST_TST:      cmd.op = OP_TST;
      ST_SQRT:     cmd.op = OP_SQRT;
      ST_DIVI:     cmd.op = OP_DIVI;
      ST_DIV:      cmd.op = OP_DIV;
      ST_N1:       cmd.op = OP_N1;
      ST_N2:       cmd.op = OP_N2;
      ST_N3:       cmd.op = OP_N3;
      ST_N4:       cmd.op = OP_N4;
      ST_N5:       cmd.op = OP_N5;
      ST_N6:       cmd.op = OP_N6;
      ST_N7:       cmd.op = OP_N7;
      ST_N8:       cmd.op = OP_N8;
      ST_N9:       cmd.op = OP_N9;
      ST_N10:      cmd.op = OP_N10;
      ST_N11:      cmd.op = OP_N11;
      ST_N12:      cmd.op = OP_N12;
      ST_FIN:      cmd.op = OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/cbcr_datapath.sv
// circle state, config registers, shared multiplier, square root and dividers
`default_nettype none
module cbcr_datapath
  import cbcr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic [1:0]           kind,
  input  wire logic signed [31:0]   box_cx,
  input  wire logic signed [31:0]   box_cy,
  input  wire logic signed [15:0]   axis_u_x,
  input  wire logic signed [15:0]   axis_u_y,
  input  wire logic signed [15:0]   axis_v_x,
  input  wire logic signed [15:0]   axis_v_y,
  input  wire logic [30:0]          box_width,
  input  wire logic [30:0]          box_height,
  input  wire cmd_t                 cmd,
  output status_t                   st,
  output logic signed [31:0]        pos_x,
  output logic signed [31:0]        pos_y,
  output logic signed [31:0]        vel_x,
  output logic signed [31:0]        vel_y,
  output logic                      hit,
  output logic                      saturated
);

  localparam logic [30:0] RADIUS_RST = 31'(RADIUS_INT << FRAC_BITS);
  localparam logic signed [71:0] MAXV = 72'sd2147483647;
  localparam logic signed [71:0] MINV = -72'sd2147483648;

  function automatic logic [32:0] sat32(input logic signed [71:0] v);
    logic [32:0] r;
    if (v > MAXV) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < MINV) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // config and circle state
  logic [30:0]        radius;
  logic signed [31:0] start_x, start_y, start_vx, start_vy;
  logic signed [31:0] cx, cy, vx, vy;

  // latched item
  logic [1:0]         kind_q;
  logic signed [31:0] bcx, bcy;
  logic signed [15:0] ux, uy, avx, avy;
  logic [29:0]        hw, hh;

  // working registers
  logic signed [32:0] dx, dy;
  logic signed [68:0] p, acc;
  logic signed [35:0] ax, ay;
  logic signed [36:0] ex, ey;
  logic [63:0]        dsq, sq_n, sq_res, sq_bit;
  logic [31:0]        dist_q;
  logic signed [32:0] ov;
  logic [31:0]        rem_x, rem_y;
  logic [14:0]        low_x, low_y, q_x, q_y;
  logic               sgn_x, sgn_y;
  logic signed [19:0] nx, ny;
  logic signed [35:0] dot;
  logic               hit_q, sat_q;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [69:0] psum;
  logic signed [35:0] cl_x, cl_y, hws, hhs;
  logic [36:0]        ex_abs, ey_abs;
  logic signed [15:0] lnx, lny;
  logic [63:0]        sq_rb;
  logic [32:0]        t_x, t_y;
  logic [32:0]        s_a, s_b, s_c, s_d, s_mx, s_my;

  assign psum   = 70'(acc) + 70'(p);
  assign hws    = $signed({6'b0, hw});
  assign hhs    = $signed({6'b0, hh});
  assign cl_x   = (ax > hws) ? hws : ((ax < -hws) ? -hws : ax);
  assign cl_y   = (ay > hhs) ? hhs : ((ay < -hhs) ? -hhs : ay);
  assign ex_abs = ex[36] ? 37'(-ex) : 37'(ex);
  assign ey_abs = ey[36] ? 37'(-ey) : 37'(ey);
  assign lnx    = sgn_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
  assign lny    = sgn_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
  assign sq_rb  = sq_res + sq_bit;
  assign t_x    = {rem_x, low_x[14]};
  assign t_y    = {rem_y, low_y[14]};

  assign st.kind = kind_q;
  assign st.far  = (ex_abs >= {6'b0, radius}) || (ey_abs >= {6'b0, radius});
  assign st.miss = (dsq >= 64'(p)) || (dsq == 64'd0);

  // position and velocity updates, push-out by floor(p/2^14), reflect by floor(p/2^13)
  assign s_a  = sat32(72'(cx) + 72'(p >>> AXIS_BITS));
  assign s_c  = sat32(72'(cy) + 72'(p >>> AXIS_BITS));
  assign s_b  = sat32(72'(vx) - 72'(p >>> (AXIS_BITS - 1)));
  assign s_d  = sat32(72'(vy) - 72'(p >>> (AXIS_BITS - 1)));
  // move tick
  assign s_mx = sat32(72'(cx) + 72'(vx));
  assign s_my = sat32(72'(cy) + 72'(vy));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_P1:   begin mul_a = 36'(dx); mul_b = 33'(ux); end
      OP_P2:   begin mul_a = 36'(dy); mul_b = 33'(uy); end
      OP_P3:   begin mul_a = 36'(dx); mul_b = 33'(avx); end
      OP_P4:   begin mul_a = 36'(dy); mul_b = 33'(avy); end
      OP_SQX:  begin mul_a = 36'($signed(ex[31:0])); mul_b = 33'($signed(ex[31:0])); end
      OP_SQY:  begin mul_a = 36'($signed(ey[31:0])); mul_b = 33'($signed(ey[31:0])); end
      OP_DSQ:  begin mul_a = $signed({5'b0, radius}); mul_b = $signed({2'b0, radius}); end
      OP_N1:   begin mul_a = 36'(lnx); mul_b = 33'(ux); end
      OP_N2:   begin mul_a = 36'(lny); mul_b = 33'(avx); end
      OP_N3:   begin mul_a = 36'(lnx); mul_b = 33'(uy); end
      OP_N4:   begin mul_a = 36'(lny); mul_b = 33'(avy); end
      OP_N5:   begin mul_a = 36'(nx); mul_b = ov; end
      OP_N6:   begin mul_a = 36'(ny); mul_b = ov; end
      OP_N7:   begin mul_a = 36'(vx); mul_b = 33'(nx); end
      OP_N8:   begin mul_a = 36'(vy); mul_b = 33'(ny); end
      OP_N10:  begin mul_a = dot; mul_b = 33'(nx); end
      OP_N11:  begin mul_a = dot; mul_b = 33'(ny); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= RADIUS_RST;
      start_x  <= '0;
      start_y  <= '0;
      start_vx <= '0;
      start_vy <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS:   radius   <= cfg_data[30:0];
        REG_START_X:  start_x  <= cfg_data;
        REG_START_Y:  start_y  <= cfg_data;
        REG_START_VX: start_vx <= cfg_data;
        REG_START_VY: start_vy <= cfg_data;
        default:      ;
      endcase
    end
  end

  // circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      vx <= '0;
      vy <= '0;
    end else begin
      unique case (cmd.op)
        OP_EXEC: begin
          if (kind_q == KIND_LOAD) begin
            cx <= start_x;
            cy <= start_y;
            vx <= start_vx;
            vy <= start_vy;
          end else if (kind_q == KIND_MOVE) begin
            cx <= s_mx[31:0];
            cy <= s_my[31:0];
          end
        end
        OP_N6:  cx <= s_a[31:0];
        OP_N7:  cy <= s_c[31:0];
        OP_N11: vx <= s_b[31:0];
        OP_N12: vy <= s_d[31:0];
        default: ;
      endcase
    end
  end

  // working registers and flags
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_q <= kind;
      bcx    <= box_cx;
      bcy    <= box_cy;
      ux     <= axis_u_x;
      uy     <= axis_u_y;
      avx    <= axis_v_x;
      avy    <= axis_v_y;
      hw     <= box_width[30:1];
      hh     <= box_height[30:1];
      hit_q  <= 1'b0;
      sat_q  <= 1'b0;
    end
    unique case (cmd.op)
      OP_EXEC: begin
        if (kind_q == KIND_MOVE) begin
          sat_q <= s_mx[32] | s_my[32];
        end
      end
      OP_DIFF: begin
        dx <= 33'(cx) - 33'(bcx);
        dy <= 33'(cy) - 33'(bcy);
      end
      OP_P1:  p <= 69'(mul_a * mul_b);
      OP_P2:  begin p <= 69'(mul_a * mul_b); acc <= p; end
      OP_P3:  begin p <= 69'(mul_a * mul_b); ax <= 36'(psum >>> AXIS_BITS); end
      OP_P4:  begin p <= 69'(mul_a * mul_b); acc <= p; end
      OP_P5:  ay <= 36'(psum >>> AXIS_BITS);
      OP_EX: begin
        ex <= 37'(ax) - 37'(cl_x);
        ey <= 37'(ay) - 37'(cl_y);
      end
      OP_SQX: p <= 69'(mul_a * mul_b);
      OP_SQY: begin p <= 69'(mul_a * mul_b); acc <= p; end
      OP_DSQ: begin dsq <= 64'(psum); p <= 69'(mul_a * mul_b); end
      OP_TST: begin
        sq_n   <= dsq;
        sq_res <= '0;
        sq_bit <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (sq_n >= sq_rb) begin
          sq_n   <= sq_n - sq_rb;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_DIVI: begin
        dist_q <= sq_res[31:0];
        ov     <= $signed({2'b0, radius}) - $signed({1'b0, sq_res[31:0]});
        rem_x  <= 32'(ex_abs >> 1);
        rem_y  <= 32'(ey_abs >> 1);
        low_x  <= {ex_abs[0], 14'b0};
        low_y  <= {ey_abs[0], 14'b0};
        sgn_x  <= ex[36];
        sgn_y  <= ey[36];
        q_x    <= '0;
        q_y    <= '0;
      end
      OP_DIV: begin
        if (t_x >= {1'b0, dist_q}) begin
          rem_x <= 32'(t_x - {1'b0, dist_q});
          q_x   <= {q_x[13:0], 1'b1};
        end else begin
          rem_x <= t_x[31:0];
          q_x   <= {q_x[13:0], 1'b0};
        end
        if (t_y >= {1'b0, dist_q}) begin
          rem_y <= 32'(t_y - {1'b0, dist_q});
          q_y   <= {q_y[13:0], 1'b1};
        end else begin
          rem_y <= t_y[31:0];
          q_y   <= {q_y[13:0], 1'b0};
        end
        low_x <= low_x << 1;
        low_y <= low_y << 1;
      end
      OP_N1:  p <= 69'(mul_a * mul_b);
      OP_N2:  begin p <= 69'(mul_a * mul_b); acc <= p; end
      OP_N3:  begin p <= 69'(mul_a * mul_b); nx <= 20'(psum >>> AXIS_BITS); end
      OP_N4:  begin p <= 69'(mul_a * mul_b); acc <= p; end
      OP_N5:  begin p <= 69'(mul_a * mul_b); ny <= 20'(psum >>> AXIS_BITS); end
      OP_N6:  begin p <= 69'(mul_a * mul_b); sat_q <= sat_q | s_a[32]; end
      OP_N7:  begin p <= 69'(mul_a * mul_b); sat_q <= sat_q | s_c[32]; end
      OP_N8:  begin p <= 69'(mul_a * mul_b); acc <= p; end
      OP_N9:  dot <= 36'(psum >>> AXIS_BITS);
      OP_N10: p <= 69'(mul_a * mul_b);
      OP_N11: begin p <= 69'(mul_a * mul_b); sat_q <= sat_q | s_b[32]; end
      OP_N12: begin
        hit_q <= 1'b1;
        sat_q <= sat_q | s_d[32];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x     <= cx;
      pos_y     <= cy;
      vel_x     <= vx;
      vel_y     <= vy;
      hit       <= hit_q;
      saturated <= sat_q;
    end
  end

endmodule
`default_nettype wire

// File: hdl/circle_box_collision_response.sv
// top level of the circle versus oriented box collision response block
//
//  channel  signals                          direction  payload
//  in       in_valid / in_ready              in         kind, box and axis fields
//  out      out_valid / out_ready            out        pos, vel, hit, saturated
//  cfg      cfg_valid / cfg_ready            in         cfg_index, cfg_data
//
// one item at a time; load, move and unused kinds go from dispatch straight to the
// hand-off; a collide ends early when one offset already rules out contact, or when
// the squared distance does, and on contact runs on through the 32-step square
// root and the 15-step paired divider on the shared unit
// reset clears the circle state to zero and the radius to 20.0
// a result waiting on out_ready holds the sequencer in its last step; the next
// item is taken as soon as that result has been handed over to the output register
`default_nettype none
module circle_box_collision_response
  import cbcr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           kind,
  input  wire logic signed [31:0]   box_cx,
  input  wire logic signed [31:0]   box_cy,
  input  wire logic signed [15:0]   axis_u_x,
  input  wire logic signed [15:0]   axis_u_y,
  input  wire logic signed [15:0]   axis_v_x,
  input  wire logic signed [15:0]   axis_v_y,
  input  wire logic [30:0]          box_width,
  input  wire logic [30:0]          box_height,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        pos_x,
  output logic signed [31:0]        pos_y,
  output logic signed [31:0]        vel_x,
  output logic signed [31:0]        vel_y,
  output logic                      hit,
  output logic                      saturated,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  cbcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .st        (st),
    .cmd       (cmd)
  );

  cbcr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .box_cx     (box_cx),
    .box_cy     (box_cy),
    .axis_u_x   (axis_u_x),
    .axis_u_y   (axis_u_y),
    .axis_v_x   (axis_v_x),
    .axis_v_y   (axis_v_y),
    .box_width  (box_width),
    .box_height (box_height),
    .cmd        (cmd),
    .st         (st),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .hit        (hit),
    .saturated  (saturated)
  );

endmodule
`default_nettype wire

// File: hdl/cbcr_checker.sv
// port-level checks for the collision block and their bind
`default_nettype none
module cbcr_checker
  import cbcr_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic signed [31:0]   pos_x,
  input wire logic signed [31:0]   vel_x,
  input wire logic                 hit,
  input wire logic                 saturated,
  input wire logic                 cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(vel_x)
      && $stable(hit) && $stable(saturated))
    else $error("result changed while stalled");

  // one item at a time: busy after a transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind circle_box_collision_response cbcr_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pos_x     (pos_x),
  .vel_x     (vel_x),
  .hit       (hit),
  .saturated (saturated),
  .cfg_ready (cfg_ready)
);
`default_nettype wire
